### rtl/levdist_pkg.sv
// ----------------------------------------------------------------------------
// levdist_pkg
// Shared constants, opcodes and controller/datapath interface structs for the
// edit distance engine.
// ----------------------------------------------------------------------------
package levdist_pkg;

  localparam int MAX_LEN_DEF   = 64;
  localparam int CHAR_BITS_DEF = 8;
  localparam int OP_W          = 2;
  localparam int CODE_W        = 8;
  localparam int FIELD_W       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR         = 2'd0,
    OP_APPEND_FIRST  = 2'd1,
    OP_APPEND_SECOND = 2'd2,
    OP_QUERY         = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic app1;
    logic drop;
    logic walk_start;
    logic rd_issue;
    logic wr_step;
    logic walk_end;
    logic q_rd;
    logic q_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fc_full;
    logic fc_zero;
    logic sc_full;
    logic sc_zero;
    logic rd_done;
  } status_t;

endpackage

### rtl/levdist_dp.sv
// ----------------------------------------------------------------------------
// levdist_dp
// Datapath: first-string store, cost row store, length counters, drop flag,
// one DP cell update per cycle and the result register.
// ----------------------------------------------------------------------------
module levdist_dp #(
  parameter int MAX_LEN   = levdist_pkg::MAX_LEN_DEF,
  parameter int CHAR_BITS = levdist_pkg::CHAR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  levdist_pkg::cmd_t                  cmd,
  input  logic [levdist_pkg::CODE_W-1:0]     in_char_code,
  output levdist_pkg::status_t               status,
  output logic [levdist_pkg::FIELD_W-1:0]    out_distance,
  output logic [levdist_pkg::FIELD_W-1:0]    out_first_length,
  output logic [levdist_pkg::FIELD_W-1:0]    out_second_length,
  output logic                               out_input_dropped
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Entry i of the cost row (i >= 1) lives at address i-1; entry 0 always
  // equals the second-string length, so it is not stored.
  logic [CHAR_BITS-1:0] first_chars_r [MAX_LEN];
  logic [CNT_W-1:0]     cost_row_r    [MAX_LEN];

  logic [CNT_W-1:0]     fc_r, sc_r, rd_cnt_r;
  logic                 dropped_r;
  logic [IDX_W-1:0]     wr_idx_r;
  logic [CNT_W-1:0]     diag_r, left_r;
  logic [CHAR_BITS-1:0] char_r;
  logic [CHAR_BITS-1:0] char_rd_r;
  logic [CNT_W-1:0]     cost_rd_r;

  logic [levdist_pkg::FIELD_W-1:0] dist_r, flen_r, slen_r;
  logic                            drop_out_r;

  logic [CHAR_BITS-1:0] char_in;
  logic [IDX_W-1:0]     fc_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_en;
  logic [CNT_W:0]       up_cost, left_cost, diag_cost, min_ul, cell_full;
  logic [CNT_W-1:0]     cell_val;

  assign char_in = CHAR_BITS'(in_char_code);
  assign fc_idx  = fc_r[IDX_W-1:0];

  assign rd_en   = cmd.rd_issue || (cmd.q_rd && !status.fc_zero);
  assign rd_addr = cmd.q_rd ? IDX_W'(fc_r - 1'b1) : rd_cnt_r[IDX_W-1:0];

  // DP cell: min of above+1, left+1, diagonal+mismatch
  always_comb begin
    up_cost   = {1'b0, cost_rd_r} + 1'b1;
    left_cost = {1'b0, left_r} + 1'b1;
    diag_cost = {1'b0, diag_r} + (CNT_W + 1)'(char_rd_r != char_r);
    min_ul    = (up_cost < left_cost) ? up_cost : left_cost;
    cell_full = (min_ul < diag_cost) ? min_ul : diag_cost;
    cell_val  = cell_full[CNT_W-1:0];
  end

  assign status.fc_full = (fc_r == CNT_W'(MAX_LEN));
  assign status.fc_zero = (fc_r == '0);
  assign status.sc_full = (sc_r == CNT_W'(MAX_LEN));
  assign status.sc_zero = (sc_r == '0);
  assign status.rd_done = (rd_cnt_r == fc_r);

  always_ff @(posedge clk) begin
    if (cmd.app1) begin
      first_chars_r[fc_idx] <= char_in;
    end
    if (rd_en) begin
      char_rd_r <= first_chars_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app1) begin
      cost_row_r[fc_idx] <= fc_r + 1'b1;
    end else if (cmd.wr_step) begin
      cost_row_r[wr_idx_r] <= cell_val;
    end
    if (rd_en) begin
      cost_rd_r <= cost_row_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= '0;
      sc_r      <= '0;
      dropped_r <= 1'b0;
      rd_cnt_r  <= '0;
    end else begin
      if (cmd.clear) begin
        fc_r      <= '0;
        sc_r      <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.app1) begin
        fc_r <= fc_r + 1'b1;
      end
      if (cmd.drop) begin
        dropped_r <= 1'b1;
      end
      if (cmd.walk_end) begin
        sc_r <= sc_r + 1'b1;
      end
      if (cmd.walk_start) begin
        rd_cnt_r <= '0;
      end else if (cmd.rd_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      char_r <= char_in;
      diag_r <= sc_r;
      left_r <= sc_r + 1'b1;
    end else if (cmd.wr_step) begin
      diag_r <= cost_rd_r;
      left_r <= cell_val;
    end
    if (cmd.rd_issue) begin
      wr_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (cmd.q_load) begin
      dist_r     <= status.fc_zero ? levdist_pkg::FIELD_W'(sc_r)
                                   : levdist_pkg::FIELD_W'(cost_rd_r);
      flen_r     <= levdist_pkg::FIELD_W'(fc_r);
      slen_r     <= levdist_pkg::FIELD_W'(sc_r);
      drop_out_r <= dropped_r;
    end
  end

  assign out_distance      = dist_r;
  assign out_first_length  = flen_r;
  assign out_second_length = slen_r;
  assign out_input_dropped = drop_out_r;

endmodule

### rtl/levdist_ctrl.sv
// ----------------------------------------------------------------------------
// levdist_ctrl
// Controller: decodes accepted transactions, sequences the cost row walk and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module levdist_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [levdist_pkg::OP_W-1:0]    in_opcode,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  levdist_pkg::status_t            status,
  output levdist_pkg::cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_QOUT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  levdist_pkg::op_t op;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign op        = levdist_pkg::op_t'(in_opcode);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            levdist_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            levdist_pkg::OP_APPEND_FIRST: begin
              if (status.fc_full || !status.sc_zero) begin
                cmd.drop = 1'b1;
              end else begin
                cmd.app1 = 1'b1;
              end
            end
            levdist_pkg::OP_APPEND_SECOND: begin
              if (status.sc_full) begin
                cmd.drop = 1'b1;
              end else begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            levdist_pkg::OP_QUERY: begin
              cmd.q_rd  = 1'b1;
              state_nxt = S_QOUT;
            end
          endcase
        end
      end
      S_WALK: begin
        // read one entry ahead, write back the entry read last cycle
        cmd.rd_issue = !status.rd_done;
        cmd.wr_step  = pend_r;
        if (status.rd_done && !pend_r) begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_QOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.q_load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_nxt = cmd.rd_issue;
    if (cmd.q_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/levenshtein_distance.sv
// ----------------------------------------------------------------------------
// levenshtein_distance
// Edit distance engine: clear, append to first/second string, query.
// Clear and first-string append take effect on acceptance; a second-string
//   append walks the cost row, one entry per cycle through the memory
//   read/write pair; a query reads the last cost row entry and loads the
//   result register once no earlier result waits, then accepts input again.
// Throughput: one transaction at a time; a waiting result holds a query but
//   does not block clears or appends. Reset (synchronous, rst_n low) empties
//   both strings and the drop flag at once; no memory sweep is needed.
// ----------------------------------------------------------------------------
module levenshtein_distance #(
  parameter int MAX_LEN   = levdist_pkg::MAX_LEN_DEF,
  parameter int CHAR_BITS = levdist_pkg::CHAR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [levdist_pkg::OP_W-1:0]    in_opcode,
  input  logic [levdist_pkg::CODE_W-1:0]  in_char_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [levdist_pkg::FIELD_W-1:0] out_distance,
  output logic [levdist_pkg::FIELD_W-1:0] out_first_length,
  output logic [levdist_pkg::FIELD_W-1:0] out_second_length,
  output logic                            out_input_dropped
);

  levdist_pkg::cmd_t    cmd;
  levdist_pkg::status_t status;

  levdist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  levdist_dp #(
    .MAX_LEN   (MAX_LEN),
    .CHAR_BITS (CHAR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_char_code      (in_char_code),
    .status            (status),
    .out_distance      (out_distance),
    .out_first_length  (out_first_length),
    .out_second_length (out_second_length),
    .out_input_dropped (out_input_dropped)
  );

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == levdist_pkg::OP_QUERY) |=> !in_ready)
    else $error("query transaction did not hold off input");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |-> !in_ready && !cmd.app1)
    else $error("cost row write outside the walk");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_end |=> in_ready)
    else $error("walk end did not return to idle");

endmodule

### dv/levenshtein_distance_check.sv
// ----------------------------------------------------------------------------
// levenshtein_distance_check
// Watches both channels of the edit distance engine. Keeps its own copy of
// the first string, the DP cost row, both lengths and the drop flag; each
// accepted query queues the expected answer, and each accepted result is
// compared field by field with the oldest pending answer.
// ----------------------------------------------------------------------------
module levenshtein_distance_check (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [levdist_pkg::OP_W-1:0]    in_opcode,
  input  logic [levdist_pkg::CODE_W-1:0]  in_char_code,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [levdist_pkg::FIELD_W-1:0] out_distance,
  input  logic [levdist_pkg::FIELD_W-1:0] out_first_length,
  input  logic [levdist_pkg::FIELD_W-1:0] out_second_length,
  input  logic                            out_input_dropped,
  output int                              err_count,
  output int                              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = levdist_pkg::MAX_LEN_DEF;

  typedef struct packed {
    logic [levdist_pkg::FIELD_W-1:0] distance;
    logic [levdist_pkg::FIELD_W-1:0] first_length;
    logic [levdist_pkg::FIELD_W-1:0] second_length;
    logic                            input_dropped;
  } edit_answer_t;

  logic [levdist_pkg::CODE_W-1:0]  word_a [MAX_LEN];
  logic [levdist_pkg::FIELD_W-1:0] len_a;
  logic [levdist_pkg::FIELD_W-1:0] len_b;
  logic [levdist_pkg::FIELD_W-1:0] cost_row [MAX_LEN+1];
  logic                            lost_flag;
  edit_answer_t                    answers_due [$];

  task automatic clear_strings();
    for (int i = 0; i <= MAX_LEN; i++) cost_row[i] = levdist_pkg::FIELD_W'(i);
    len_a     = '0;
    len_b     = '0;
    lost_flag = 1'b0;
  endtask

  // One DP step of the cost row per second-string character.
  task automatic advance_row(input logic [levdist_pkg::CODE_W-1:0] ch);
    logic [levdist_pkg::FIELD_W-1:0] diag;
    logic [levdist_pkg::FIELD_W-1:0] best;
    logic [levdist_pkg::FIELD_W-1:0] sub;
    diag        = cost_row[0];
    cost_row[0] = len_b + 1'b1;
    for (int i = 1; i <= int'(len_a); i++) begin
      sub  = diag + ((word_a[i-1] == ch) ? 7'd0 : 7'd1);
      best = cost_row[i] + 1'b1;
      if (cost_row[i-1] + 1'b1 < best) best = cost_row[i-1] + 1'b1;
      if (sub < best) best = sub;
      diag        = cost_row[i];
      cost_row[i] = best;
    end
    len_b = len_b + 1'b1;
  endtask

  task automatic apply_edit_op(input levdist_pkg::op_t op,
                               input logic [levdist_pkg::CODE_W-1:0] ch);
    edit_answer_t ans;
    case (op)
      levdist_pkg::OP_CLEAR: clear_strings();
      levdist_pkg::OP_APPEND_FIRST: begin
        if (len_a >= MAX_LEN || len_b != 0) begin
          lost_flag = 1'b1;
        end else begin
          word_a[len_a] = ch;
          len_a         = len_a + 1'b1;
          cost_row[len_a] = len_a;
        end
      end
      levdist_pkg::OP_APPEND_SECOND: begin
        if (len_b >= MAX_LEN) lost_flag = 1'b1;
        else advance_row(ch);
      end
      default: begin
        ans.distance      = cost_row[len_a];
        ans.first_length  = len_a;
        ans.second_length = len_b;
        ans.input_dropped = lost_flag;
        answers_due.insert(answers_due.size(), ans);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    edit_answer_t due;
    if (!rst_n) begin
      clear_strings();
      answers_due.delete();
      err_count = 0;
    end else begin
      // results first: a result at this edge belongs to an earlier query
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result transaction with no query pending");
          err_count++;
        end else begin
          due = answers_due.pop_front();
          check_field("distance", due.distance, out_distance);
          check_field("first_length", due.first_length, out_first_length);
          check_field("second_length", due.second_length, out_second_length);
          check_field("input_dropped", due.input_dropped, out_input_dropped);
        end
      end
      if (in_valid && in_ready) begin
        apply_edit_op(levdist_pkg::op_t'(in_opcode), in_char_code);
      end
    end
    pending_count = answers_due.size();
  end

endmodule

### dv/levenshtein_distance_test.sv
// ----------------------------------------------------------------------------
// levenshtein_distance_test
// Drives the edit distance engine with a short directed list, full-length
// boundary pairs and random string pairs mixed with noise, under random
// idling on both channels. Checking is done by levenshtein_distance_check.
// ----------------------------------------------------------------------------
module levenshtein_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL   = 950;
  localparam int STALL_LIMIT = 5000;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [levdist_pkg::OP_W-1:0]     in_opcode;
  logic [levdist_pkg::CODE_W-1:0]   in_char_code;
  logic                             out_valid;
  logic                             out_ready;
  logic [levdist_pkg::FIELD_W-1:0]  out_distance;
  logic [levdist_pkg::FIELD_W-1:0]  out_first_length;
  logic [levdist_pkg::FIELD_W-1:0]  out_second_length;
  logic                             out_input_dropped;
  int                               err_count;
  int                               pending_count;
  int                               idle_pct;
  int                               items_sent;
  int                               quiet_cycles;

  levenshtein_distance i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance      (out_distance),
    .out_first_length  (out_first_length),
    .out_second_length (out_second_length),
    .out_input_dropped (out_input_dropped)
  );

  levenshtein_distance_check i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance      (out_distance),
    .out_first_length  (out_first_length),
    .out_second_length (out_second_length),
    .out_input_dropped (out_input_dropped),
    .err_count         (err_count),
    .pending_count     (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = levdist_pkg::OP_CLEAR;
    in_char_code = '0;
    out_ready    = 1'b0;
    idle_pct     = 13;
    items_sent   = 0;
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= idle_pct);

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** levenshtein_distance: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_edit_op(input levdist_pkg::op_t op,
                              input logic [levdist_pkg::CODE_W-1:0] ch);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_opcode    = op;
    in_char_code = ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [levdist_pkg::CODE_W-1:0] pick_char(input bit narrow);
    if (narrow) return 8'h61 + levdist_pkg::CODE_W'($urandom_range(3));
    return levdist_pkg::CODE_W'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(10);
    if (roll < 95) return $urandom_range(40, 11);
    return $urandom_range(66, 60);
  endfunction

  // Usually clear, build first string, stream second with queries mixed in.
  task automatic run_pair(input int len_first, input int len_second, input bit narrow);
    if ($urandom_range(9) != 0) send_edit_op(levdist_pkg::OP_CLEAR, pick_char(0));
    for (int i = 0; i < len_first; i++) begin
      send_edit_op(levdist_pkg::OP_APPEND_FIRST, pick_char(narrow));
      if ($urandom_range(19) == 0) send_edit_op(levdist_pkg::OP_QUERY, pick_char(0));
    end
    for (int i = 0; i < len_second; i++) begin
      send_edit_op(levdist_pkg::OP_APPEND_SECOND, pick_char(narrow));
      if ($urandom_range(19) == 0) begin
        send_edit_op(levdist_pkg::OP_APPEND_FIRST, pick_char(narrow));
      end
      if ($urandom_range(3) == 0) send_edit_op(levdist_pkg::OP_QUERY, pick_char(0));
    end
    send_edit_op(levdist_pkg::OP_QUERY, pick_char(0));
  endtask

  task automatic run_noise();
    int count;
    count = $urandom_range(10, 4);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_edit_op(levdist_pkg::OP_CLEAR, pick_char(0));
      else send_edit_op(levdist_pkg::op_t'($urandom_range(3, 1)), pick_char(0));
    end
  endtask

  initial begin
    int pairs;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty strings, extreme bytes, late first append, clear
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_SECOND, 8'h00);
    send_edit_op(levdist_pkg::OP_QUERY, 8'hFF);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'h41);
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_CLEAR, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'hFF);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'h55);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'hAA);
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_SECOND, 8'hFF);
    send_edit_op(levdist_pkg::OP_APPEND_SECOND, 8'h00);
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_SECOND, 8'hAA);
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_APPEND_FIRST, 8'h01);
    send_edit_op(levdist_pkg::OP_QUERY, 8'h00);
    send_edit_op(levdist_pkg::OP_CLEAR, 8'hFF);
    send_edit_op(levdist_pkg::OP_QUERY, 8'hFF);
    wait_drained();

    // both strings past full, so both overflow drops are taken
    run_pair(66, 66, 1'b1);
    wait_drained();
    pairs = 0;

    while (items_sent < ITEM_GOAL) begin
      // hold a long stretch without idling on either side
      idle_pct = (items_sent >= 300 && items_sent < 450) ? 0 : 13;
      if ($urandom_range(9) == 0) run_noise();
      else if ($urandom_range(29) == 0) begin
        run_pair(64, $urandom_range(66, 60), 1'($urandom_range(1)));
      end
      else run_pair(pick_len(), pick_len(), $urandom_range(99) < 70);
      pairs++;
      if (pairs % 15 == 0) wait_drained();
    end

    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (err_count == 0) begin
      $display("** levenshtein_distance: PASSED **");
    end else begin
      $display("** levenshtein_distance: FAILED **");
    end
    $finish;
  end

endmodule
